// ----- src/ccpr_pkg.sv -----
// ----------------------------------------------------------------------------
// ccpr_pkg: shared types and constants for the character class refiner
// Request/result payloads, request codes, controller states and the
// command/status groups between controller and datapath.
// ----------------------------------------------------------------------------
package ccpr_pkg;

  localparam int ALPHABET_SIZE_DEF = 256;
  localparam int SYM_W             = 8;
  localparam int CLS_W             = 8;
  localparam int CNT_W             = 9;
  localparam int CLS_LIMIT         = 256;

  localparam logic [1:0] REQ_INIT    = 2'd0;
  localparam logic [1:0] REQ_REFINE  = 2'd1;
  localparam logic [1:0] REQ_ISOLATE = 2'd2;
  localparam logic [1:0] REQ_QUERY   = 2'd3;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [SYM_W-1:0] symbol;
    logic             last;
  } req_t;

  typedef struct packed {
    logic [CLS_W-1:0] symbol_class;
    logic [CNT_W-1:0] class_count;
  } res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD,
    ST_RESP,
    ST_SP_MEM,
    ST_SP_CLS,
    ST_SP_CHK,
    ST_SP_SCAN,
    ST_SP_DRAIN,
    ST_SP_END,
    ST_ISO_RD,
    ST_ISO_CLS,
    ST_ISO_SCAN,
    ST_ISO_DRAIN,
    ST_ISO_END
  } state_t;

  typedef struct packed {
    logic accept;         // request transfer this cycle
    logic rd_map_member;  // read map at member just fetched
    logic rd_map_sym;     // read map at latched symbol
    logic visit;          // start split scan of a fresh class
    logic k_inc;          // skip member whose class was handled
    logic scan_issue;     // issue one map read of the byte scan
    logic split_end;      // close one class split
    logic iso_start;      // start isolate scan
    logic iso_end;        // commit isolate
    logic set_clear;      // drop the loaded set
  } ctrl_cmd_t;

  typedef struct packed {
    logic sym_ok;
    logic k_lt_cnt;
    logic visited_hit;
    logic scan_last;
  } dp_stat_t;

endpackage

// ----- src/ccpr_ctrl.sv -----
// ----------------------------------------------------------------------------
// ccpr_ctrl: sequencer for the character class refiner
// Walks each request through its read, scan and response steps and
// drives the datapath by command strobes.
// ----------------------------------------------------------------------------
module ccpr_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  ccpr_pkg::req_t      request,
  input  ccpr_pkg::dp_stat_t  stat,
  output ccpr_pkg::ctrl_cmd_t cmd,
  output logic                busy,
  output logic                done
);

  ccpr_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ccpr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ccpr_pkg::ST_IDLE: begin
        if (start) begin
          unique case (request.req_type)
            ccpr_pkg::REQ_INIT:    state_next = ccpr_pkg::ST_RD;
            ccpr_pkg::REQ_REFINE:  state_next = request.last ? ccpr_pkg::ST_SP_MEM
                                                             : ccpr_pkg::ST_IDLE;
            ccpr_pkg::REQ_ISOLATE: state_next = ccpr_pkg::ST_ISO_RD;
            ccpr_pkg::REQ_QUERY:   state_next = ccpr_pkg::ST_RD;
            default:               state_next = ccpr_pkg::ST_RD;
          endcase
        end
      end
      ccpr_pkg::ST_RD:        state_next = ccpr_pkg::ST_RESP;
      ccpr_pkg::ST_RESP:      state_next = ccpr_pkg::ST_IDLE;
      ccpr_pkg::ST_SP_MEM:    state_next = stat.k_lt_cnt ? ccpr_pkg::ST_SP_CLS
                                                         : ccpr_pkg::ST_RD;
      ccpr_pkg::ST_SP_CLS:    state_next = ccpr_pkg::ST_SP_CHK;
      ccpr_pkg::ST_SP_CHK:    state_next = stat.visited_hit ? ccpr_pkg::ST_SP_MEM
                                                            : ccpr_pkg::ST_SP_SCAN;
      ccpr_pkg::ST_SP_SCAN:   state_next = stat.scan_last ? ccpr_pkg::ST_SP_DRAIN
                                                          : ccpr_pkg::ST_SP_SCAN;
      ccpr_pkg::ST_SP_DRAIN:  state_next = ccpr_pkg::ST_SP_END;
      ccpr_pkg::ST_SP_END:    state_next = ccpr_pkg::ST_SP_MEM;
      ccpr_pkg::ST_ISO_RD:    state_next = stat.sym_ok ? ccpr_pkg::ST_ISO_CLS
                                                       : ccpr_pkg::ST_RD;
      ccpr_pkg::ST_ISO_CLS:   state_next = ccpr_pkg::ST_ISO_SCAN;
      ccpr_pkg::ST_ISO_SCAN:  state_next = stat.scan_last ? ccpr_pkg::ST_ISO_DRAIN
                                                          : ccpr_pkg::ST_ISO_SCAN;
      ccpr_pkg::ST_ISO_DRAIN: state_next = ccpr_pkg::ST_ISO_END;
      ccpr_pkg::ST_ISO_END:   state_next = ccpr_pkg::ST_RD;
      default:                state_next = ccpr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = (state != ccpr_pkg::ST_IDLE);
    done = (state == ccpr_pkg::ST_RESP);
    unique case (state)
      ccpr_pkg::ST_IDLE:     cmd.accept        = start;
      ccpr_pkg::ST_RD:       cmd.rd_map_sym    = 1'b1;
      ccpr_pkg::ST_SP_MEM:   cmd.set_clear     = !stat.k_lt_cnt;
      ccpr_pkg::ST_SP_CLS:   cmd.rd_map_member = 1'b1;
      ccpr_pkg::ST_SP_CHK: begin
        cmd.visit = !stat.visited_hit;
        cmd.k_inc = stat.visited_hit;
      end
      ccpr_pkg::ST_SP_SCAN:  cmd.scan_issue    = 1'b1;
      ccpr_pkg::ST_SP_END:   cmd.split_end     = 1'b1;
      ccpr_pkg::ST_ISO_RD:   cmd.rd_map_sym    = 1'b1;
      ccpr_pkg::ST_ISO_CLS:  cmd.iso_start     = 1'b1;
      ccpr_pkg::ST_ISO_SCAN: cmd.scan_issue    = 1'b1;
      ccpr_pkg::ST_ISO_END:  cmd.iso_end       = 1'b1;
      default:               cmd               = '0;
    endcase
  end

endmodule

// ----- src/ccpr_dp.sv -----
// ----------------------------------------------------------------------------
// ccpr_dp: datapath of the character class refiner
// Byte-to-class map RAM with per-entry valid bits, set and visited masks,
// member list RAM, class counter and the pipelined byte scan.
// ----------------------------------------------------------------------------
module ccpr_dp #(
  parameter int ALPHABET_SIZE = ccpr_pkg::ALPHABET_SIZE_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  ccpr_pkg::req_t      request,
  input  ccpr_pkg::ctrl_cmd_t cmd,
  output ccpr_pkg::dp_stat_t  stat,
  output ccpr_pkg::res_t      result
);

  localparam int AW = $clog2(ALPHABET_SIZE);
  localparam int CNT_W = ccpr_pkg::CNT_W;
  localparam int CLS_W = ccpr_pkg::CLS_W;
  localparam int SYM_W = ccpr_pkg::SYM_W;
  localparam logic [CNT_W-1:0] ASIZE  = CNT_W'(ALPHABET_SIZE);
  localparam logic [CNT_W-1:0] CLIMIT = CNT_W'(ccpr_pkg::CLS_LIMIT);
  localparam logic [AW-1:0]    LAST_B = AW'(ALPHABET_SIZE - 1);

  // storage
  logic [CLS_W-1:0]         map_mem [ALPHABET_SIZE];
  logic [SYM_W-1:0]         mlist_mem [ALPHABET_SIZE];
  logic [ALPHABET_SIZE-1:0] map_vld;
  logic [ALPHABET_SIZE-1:0] set_mask;
  logic [ALPHABET_SIZE-1:0] visited;

  // registers
  logic [CLS_W-1:0] map_rd;
  logic             rd_vld;
  logic [SYM_W-1:0] mlist_rd;
  logic [SYM_W-1:0] sym;
  logic             sym_ok;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] mcount;
  logic [CNT_W-1:0] k;
  logic [AW-1:0]    b;
  logic             p_vld;
  logic [AW-1:0]    p_addr;
  logic [CLS_W-1:0] cls_reg;
  logic             moved;
  logic             shared;
  logic             scan_iso;

  // combinational
  logic [CLS_W-1:0] cls_rd;
  logic [AW-1:0]    raddr;
  logic [AW-1:0]    waddr;
  logic             map_we;
  logic             split_we;
  logic             iso_we;
  logic             iso_hit;
  logic             in_ok;
  logic [AW-1:0]    in_idx;
  logic [AW-1:0]    sym_idx;
  logic             load;

  assign in_ok   = ({1'b0, request.symbol} < ASIZE);
  assign in_idx  = request.symbol[AW-1:0];
  assign sym_idx = sym[AW-1:0];
  assign cls_rd  = rd_vld ? map_rd : '0;

  assign load = cmd.accept && (request.req_type == ccpr_pkg::REQ_REFINE) &&
                in_ok && !set_mask[in_idx];

  always_comb begin
    priority if (cmd.rd_map_member) begin
      raddr = mlist_rd[AW-1:0];
    end else if (cmd.rd_map_sym) begin
      raddr = sym_idx;
    end else begin
      raddr = b;
    end
  end

  // scan compare runs in the cycle after the read it issued
  assign split_we = p_vld && !scan_iso && (cls_rd == cls_reg) && !set_mask[p_addr];
  assign iso_hit  = p_vld && scan_iso && (cls_rd == cls_reg) && (p_addr != sym_idx);
  assign iso_we   = cmd.iso_end && shared && (count != CLIMIT);
  assign map_we   = split_we || iso_we;
  assign waddr    = iso_we ? sym_idx : p_addr;

  always_ff @(posedge clk) begin
    if (map_we) begin
      map_mem[waddr] <= count[CLS_W-1:0];
    end
    map_rd <= map_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (load) begin
      mlist_mem[mcount[AW-1:0]] <= request.symbol;
    end
    mlist_rd <= mlist_mem[k[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    p_addr <= b;
    if (cmd.accept) begin
      sym    <= request.symbol;
      sym_ok <= in_ok;
    end
    if (cmd.visit || cmd.iso_start) begin
      cls_reg <= cls_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      map_vld  <= '0;
      rd_vld   <= 1'b0;
      set_mask <= '0;
      visited  <= '0;
      count    <= CNT_W'(1);
      mcount   <= '0;
      k        <= '0;
      b        <= '0;
      p_vld    <= 1'b0;
      moved    <= 1'b0;
      shared   <= 1'b0;
      scan_iso <= 1'b0;
    end else begin
      rd_vld <= map_vld[raddr];
      p_vld  <= cmd.scan_issue;
      if (map_we) begin
        map_vld[waddr] <= 1'b1;
      end
      if (cmd.accept && (request.req_type == ccpr_pkg::REQ_INIT)) begin
        map_vld  <= '0;
        count    <= CNT_W'(1);
        set_mask <= '0;
        visited  <= '0;
        mcount   <= '0;
        k        <= '0;
      end
      if (load) begin
        set_mask[in_idx] <= 1'b1;
        mcount           <= mcount + CNT_W'(1);
      end
      if (cmd.visit) begin
        visited[cls_rd[AW-1:0]] <= 1'b1;
        moved    <= 1'b0;
        b        <= '0;
        scan_iso <= 1'b0;
      end
      if (cmd.iso_start) begin
        shared   <= 1'b0;
        b        <= '0;
        scan_iso <= 1'b1;
      end
      if (cmd.scan_issue) begin
        b <= b + AW'(1);
      end
      if (split_we) begin
        moved <= 1'b1;
      end
      if (iso_hit) begin
        shared <= 1'b1;
      end
      if (cmd.k_inc) begin
        k <= k + CNT_W'(1);
      end
      if (cmd.split_end) begin
        k <= k + CNT_W'(1);
        if (moved && (count != CLIMIT)) begin
          count <= count + CNT_W'(1);
        end
      end
      if (iso_we) begin
        count <= count + CNT_W'(1);
      end
      if (cmd.set_clear) begin
        set_mask <= '0;
        visited  <= '0;
        mcount   <= '0;
        k        <= '0;
      end
    end
  end

  assign stat.sym_ok      = sym_ok;
  assign stat.k_lt_cnt    = (k < mcount);
  assign stat.visited_hit = visited[cls_rd[AW-1:0]];
  assign stat.scan_last   = (b == LAST_B);

  assign result.symbol_class = sym_ok ? cls_rd : '0;
  assign result.class_count  = count;

endmodule

// ----- src/char_class_partition_refiner_core.sv -----
// ----------------------------------------------------------------------------
// char_class_partition_refiner_core: byte equivalence class refiner
// Partition of the byte alphabet into classes with init, set refinement,
// single-byte isolation and class query.
// ----------------------------------------------------------------------------
// A request transfers when start is high and busy is low. Every request but a
// refine member without last returns one result on result, with done high for
// one cycle; there is no back pressure, so take it in that cycle. The map is a
// RAM with one read and one write port, scanned one byte per cycle. Init and
// query pass through accept, map read and result; isolate reads the byte's
// class, scans and commits if the byte is in range, then map read and result;
// the last refine member reads each distinct member's class and scans the map
// once per class they touch. No clearing pass is needed after reset.
module char_class_partition_refiner_core #(
  parameter int ALPHABET_SIZE = ccpr_pkg::ALPHABET_SIZE_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  ccpr_pkg::req_t request,
  output logic           busy,
  output logic           done,
  output ccpr_pkg::res_t result
);

  ccpr_pkg::ctrl_cmd_t cmd;
  ccpr_pkg::dp_stat_t  stat;

  ccpr_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .request (request),
    .stat    (stat),
    .cmd     (cmd),
    .busy    (busy),
    .done    (done)
  );

  ccpr_dp #(
    .ALPHABET_SIZE (ALPHABET_SIZE)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .cmd     (cmd),
    .stat    (stat),
    .result  (result)
  );

  // result strobe only while busy, so no request can transfer in that cycle
  a_done_busy : assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("result strobe outside busy");

  a_done_single : assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  // class count never exceeds the alphabet and never drops to zero
  a_count_range : assert property (@(posedge clk) disable iff (rst)
    done |-> (result.class_count != '0) &&
             (result.class_count <= ccpr_pkg::CNT_W'(ALPHABET_SIZE)))
    else $error("class count out of range");

  a_query_lat : assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (request.req_type == ccpr_pkg::REQ_QUERY)) |=> ##1 done)
    else $error("query result late");

endmodule
